// File: rtl/core/vtpd_pkg.sv
// shared constants and types for the vertex transform with perspective divide
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;
  localparam int FracBitsDefault = 16;
  localparam int CfgRegs = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgW = 64;
  localparam int WordW = 32;
  localparam int SumW = 67;
  localparam int NumW = SumW + 24;
  localparam int QuoW = 36;
  typedef enum logic [1:0] {
    StatOk   = 2'd0,
    StatWZero = 2'd1,
    StatSat  = 2'd2
  } status_e;
  typedef struct packed {
    logic w_zero;
  } div_ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/vtpd_dot.sv
// pipelined column dot products: stage 1 multiplies, stage 2 sums
`timescale 1ns / 1ps
`default_nettype none
module vtpd_dot import vtpd_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic signed [WordW-1:0]     px_i,
  input  wire logic signed [WordW-1:0]     py_i,
  input  wire logic signed [WordW-1:0]     pz_i,
  input  wire logic [CfgRegs-1:0][CfgW-1:0] cfg_i,
  output logic                             valid_o,
  output logic signed [SumW-1:0]           sum_o [4]
);
  logic signed [2*WordW-1:0] prod_q [4][4];
  logic valid1_q;
  logic signed [WordW-1:0] ent [4][4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = (c % 2 == 1) ? $signed(cfg_i[r*2 + c/2][WordW-1:0])
                                 : $signed(cfg_i[r*2 + c/2][CfgW-1:WordW]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid_o  <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      prod_q[0][c] <= px_i * ent[0][c];
      prod_q[1][c] <= py_i * ent[1][c];
      prod_q[2][c] <= pz_i * ent[2][c];
      prod_q[3][c] <= 64'(ent[3][c]) <<< FracBits;
    end
    for (int c = 0; c < 4; c++) begin
      sum_o[c] <= SumW'(prod_q[0][c]) + SumW'(prod_q[1][c])
                + SumW'(prod_q[2][c]) + SumW'(prod_q[3][c]);
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/vtpd_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module vtpd_div import vtpd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [SumW-1:0]   den_i,
  input  wire logic              neg_i,
  output logic                   valid_o,
  output logic [QuoW-1:0]        quo_o,
  output logic                   big_o,
  output logic                   neg_o
);
  // quotients needing bits at or above QuoW saturate anyway
  logic [QuoW:0]      v_q;
  logic [NumW-1:0]    rem_q [QuoW+1];
  logic [SumW-1:0]    den_q [QuoW+1];
  logic [QuoW-1:0]    quo_q [QuoW+1];
  logic               big_q [QuoW+1];
  logic               neg_q [QuoW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[QuoW-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    neg_q[0] <= neg_i;
    big_q[0] <= (num_i >> QuoW) >= NumW'(den_i);
    for (int s = 0; s < QuoW; s++) begin
      automatic int b = QuoW - 1 - s;
      automatic logic [NumW-1:0] dsh = NumW'(den_q[s]) << b;
      automatic logic fit = ((rem_q[s] >> b) >= NumW'(den_q[s]));
      rem_q[s+1] <= fit ? rem_q[s] - dsh : rem_q[s];
      quo_q[s+1] <= quo_q[s] | (QuoW'(fit) << b);
      den_q[s+1] <= den_q[s];
      big_q[s+1] <= big_q[s];
      neg_q[s+1] <= neg_q[s];
    end
  end

  assign valid_o = v_q[QuoW];
  assign quo_o = quo_q[QuoW];
  assign big_o = big_q[QuoW];
  assign neg_o = neg_q[QuoW];
endmodule
`default_nettype wire

// File: rtl/core/vertex_transform_perspective_divide.sv
// top level: point by 4x4 matrix, then divide x, y, z by w
// pipeline order: dot product, sign prep, divider, output register
// throughput: one point per cycle; the divider stages make up most of the pipeline depth
// reset: matrix returns to identity, all valid bits clear
// the receiver cannot stall; each result strobes done_o for one cycle
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_perspective_divide import vtpd_pkg::*; #(
  parameter int FracBits = FracBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic signed [WordW-1:0] point_x_i,
  input  wire logic signed [WordW-1:0] point_y_i,
  input  wire logic signed [WordW-1:0] point_z_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0]         cfg_data_i,
  output logic                         done_o,
  output logic signed [WordW-1:0]      out_x_o,
  output logic signed [WordW-1:0]      out_y_o,
  output logic signed [WordW-1:0]      out_z_o,
  output logic [1:0]                   status_o
);
  localparam logic [CfgRegs-1:0][CfgW-1:0] CfgReset = {
    CfgW'(1) << FracBits, CfgW'(0), CfgW'(1) << (WordW + FracBits), CfgW'(0),
    CfgW'(0), CfgW'(1) << FracBits, CfgW'(0), CfgW'(1) << (WordW + FracBits)
  };

  logic [CfgRegs-1:0][CfgW-1:0] cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign busy_o = 1'b0;

  logic dot_v;
  logic signed [SumW-1:0] sum [4];
  vtpd_dot #(.FracBits(FracBits)) u_dot (
    .clk_i, .rst_ni, .valid_i(start_i), .px_i(point_x_i), .py_i(point_y_i),
    .pz_i(point_z_i), .cfg_i(cfg_q), .valid_o(dot_v), .sum_o(sum)
  );

  // sign and magnitude prep
  logic prep_v_q;
  logic [NumW-1:0] num_q [3];
  logic [SumW-1:0] den_q;
  logic neg_q [3];
  div_ctl_t ctl_prep_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prep_v_q <= 1'b0;
    else prep_v_q <= dot_v;
  end
  always_ff @(posedge clk_i) begin
    ctl_prep_q <= '{w_zero: (sum[3] == '0)};
    den_q <= sum[3][SumW-1] ? SumW'(-sum[3]) : SumW'(sum[3]);
    for (int c = 0; c < 3; c++) begin
      automatic logic [SumW-1:0] mag = sum[c][SumW-1] ? SumW'(-sum[c]) : SumW'(sum[c]);
      num_q[c] <= NumW'(mag) << FracBits;
      neg_q[c] <= sum[c][SumW-1] ^ sum[3][SumW-1];
    end
  end

  // zero-w flag rides a shift line alongside the dividers
  logic [QuoW:0] wz_line_q;
  always_ff @(posedge clk_i) wz_line_q <= {wz_line_q[QuoW-1:0], ctl_prep_q.w_zero};

  logic dv [3];
  logic [QuoW-1:0] quo [3];
  logic big [3];
  logic qn [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    vtpd_div u_div (
      .clk_i, .rst_ni, .valid_i(prep_v_q), .num_i(num_q[c]),
      .den_i(ctl_prep_q.w_zero ? SumW'(1) : den_q), .neg_i(neg_q[c]),
      .valid_o(dv[c]), .quo_o(quo[c]), .big_o(big[c]), .neg_o(qn[c])
    );
  end

  logic signed [WordW-1:0] res [3];
  logic sat [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      automatic logic [QuoW-1:0] lim = qn[c] ? QuoW'(33'h080000000) : QuoW'(32'h7fffffff);
      sat[c] = big[c] || (quo[c] > lim);
      if (sat[c]) res[c] = qn[c] ? 32'sh80000000 : 32'sh7fffffff;
      else res[c] = qn[c] ? WordW'(-quo[c]) : WordW'(quo[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= dv[0];
  end
  always_ff @(posedge clk_i) begin
    if (wz_line_q[QuoW]) begin
      out_x_o <= '0; out_y_o <= '0; out_z_o <= '0;
      status_o <= StatWZero;
    end else begin
      out_x_o <= res[0]; out_y_o <= res[1]; out_z_o <= res[2];
      status_o <= (sat[0] || sat[1] || sat[2]) ? StatSat : StatOk;
    end
  end

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[0] == dv[1] && dv[1] == dv[2]) else $error("divider lanes out of step");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[0] |=> done_o) else $error("lost result");
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// testbench for the vertex transform with perspective divide: random and directed points
`timescale 1ns / 1ps
module tb_top;
  import vtpd_pkg::*;

  localparam int Frac = FracBitsDefault;
  localparam int Latency = 41;

  typedef struct packed {
    logic signed [WordW-1:0] x;
    logic signed [WordW-1:0] y;
    logic signed [WordW-1:0] z;
    status_e                 status;
  } vertex_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [WordW-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [WordW-1:0] out_x_o, out_y_o, out_z_o;
  logic [1:0] status_o;

  logic [CfgW-1:0] matrix_regs [CfgRegs];
  vertex_res_t pending_vertices [$];
  int errors = 0;

  vertex_transform_perspective_divide i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic signed [WordW-1:0] mat_entry(int r, int c);
    logic [CfgW-1:0] reg_val;
    reg_val = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? reg_val[31:0] : reg_val[63:32];
  endfunction

  function automatic logic signed [127:0] column_sum(logic signed [WordW-1:0] x,
      logic signed [WordW-1:0] y, logic signed [WordW-1:0] z, int c);
    logic signed [127:0] acc;
    acc = 128'(x) * 128'(mat_entry(0, c));
    acc += 128'(y) * 128'(mat_entry(1, c));
    acc += 128'(z) * 128'(mat_entry(2, c));
    acc += 128'(mat_entry(3, c)) <<< Frac;
    return acc;
  endfunction

  function automatic vertex_res_t transform_vertex(logic signed [WordW-1:0] x,
      logic signed [WordW-1:0] y, logic signed [WordW-1:0] z);
    vertex_res_t r;
    logic signed [127:0] w, n, q;
    logic [WordW-1:0] o [3];
    logic sat;
    sat = 1'b0;
    w = column_sum(x, y, z, 3);
    if (w == 0) begin
      r = '{x: '0, y: '0, z: '0, status: StatWZero};
      return r;
    end
    for (int c = 0; c < 3; c++) begin
      n = column_sum(x, y, z, c) <<< Frac;
      q = n / w;
      if (q > 128'sh7FFFFFFF) begin
        sat = 1'b1;
        o[c] = 32'h7FFFFFFF;
      end else if (q < -128'sh80000000) begin
        sat = 1'b1;
        o[c] = 32'h80000000;
      end else begin
        o[c] = q[31:0];
      end
    end
    r = '{x: o[0], y: o[1], z: o[2], status: sat ? StatSat : StatOk};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    vertex_res_t e;
    if (rst_ni && done_o) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, status_o}, '0);
      end else begin
        e = pending_vertices.pop_front();
        if (out_x_o !== e.x) report_mismatch("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report_mismatch("out_y", out_y_o, e.y);
        if (out_z_o !== e.z) report_mismatch("out_z", out_z_o, e.z);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
      end
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    // close any register write still open
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    pending_vertices.push_back(transform_vertex(x, y, z));
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_cfg(int idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[CfgIdxW-1:0];
    cfg_data_i <= val;
    @(posedge clk_i);
    matrix_regs[idx] = val;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFFFFFF;
      3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'h00010000;
      2: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_identity_directed;
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h00010000);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_point(32'h00018000, 32'hFFFE8000, 32'h00000001);
    drain();
  endtask

  task automatic test_zero_w_and_saturation;
    // w taken from z only, so z of zero gives zero w
    write_cfg(5, {32'h00000000, 32'h00010000});
    write_cfg(7, {32'h00000000, 32'h00000000});
    write_cfg(2, {32'h00010000, 32'h00000000});
    send_point(32'h00010000, 32'h00020000, 32'h0);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h00000001);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_point(32'h00030000, 32'hFFFD0000, 32'h00020000);
    send_point(32'h00000007, 32'hFFFFFFF9, 32'hFFFD0000);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    drain();
  endtask

  task automatic test_extreme_matrix;
    for (int i = 0; i < CfgRegs; i++) write_cfg(i, '1);
    send_point(32'h00010000, 32'h0, 32'h0);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    drain();
    for (int i = 0; i < CfgRegs; i++) write_cfg(i, {32'h80000000, 32'h7FFFFFFF});
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h00000001);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < CfgRegs; i++) write_cfg(i, {rand_entry(), rand_entry()});
      for (int k = 0; k < 50; k++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  initial begin
    matrix_regs = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
                    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_directed();
    test_zero_w_and_saturation();
    test_extreme_matrix();
    test_random();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
